@@ rtl/core/heading_to_point_pid_assert.svh @@
// assertion macros for the heading to point turn controller
`ifndef HEADING_TO_POINT_PID_ASSERT_SVH
`define HEADING_TO_POINT_PID_ASSERT_SVH

// clocked assertion, off while reset is held
`define HPID_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("heading_to_point_pid check failed");

// plain clocked assertion, also checked during reset
`define HPID_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("heading_to_point_pid check failed");

`endif

@@ rtl/core/hpid_pkg.sv @@
// ----------------------------------------------------------------------------
// hpid_pkg
// shared constants, register indexes and the arctangent table of the
// heading to point turn controller
// ----------------------------------------------------------------------------
package hpid_pkg;

    localparam int HPID_CORDIC_STEPS = 16;

    // angles in q12 radians
    localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
    localparam logic signed [17:0] PI_Q12      = 18'sd12868;
    // near-y distance of 7 units in q8
    localparam logic [24:0]        NEAR_Y_Q8   = 25'd1792;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_I   = 3'd1;
    localparam logic [2:0] CFG_GAIN_D   = 3'd2;
    localparam logic [2:0] CFG_FORWARD  = 3'd3;
    localparam logic [2:0] CFG_GOAL_X   = 3'd4;
    localparam logic [2:0] CFG_GOAL_Y   = 3'd5;
    localparam logic [2:0] CFG_I_WINDOW = 3'd6;

    typedef logic signed [47:0] t_cordic_vec;

    // atan(2^-i) in q20
    function automatic logic [19:0] atan_q20(input logic [4:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/hpid_cordic.sv @@
// ----------------------------------------------------------------------------
// hpid_cordic
// iterative vectoring cordic, one shift-add rotation per cycle, gives
// atan(a/b) in q12 for a >= 0 and b > 0
// ----------------------------------------------------------------------------
module hpid_cordic import hpid_pkg::*; #(
    parameter int CORDIC_STEPS = HPID_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [24:0] i_a,
    input  logic [24:0] i_b,
    output logic        o_done,
    output logic [13:0] o_angle
);

    localparam int CW = $clog2(CORDIC_STEPS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    logic               r_busy, r_done;
    logic [CW-1:0]      r_cnt;
    t_cordic_vec        r_x, r_y;
    logic signed [23:0] r_z;

    t_cordic_vec        xs, ys;
    logic signed [23:0] step_ang;
    logic signed [23:0] z_clamped;
    logic [23:0]        z_round;

    always_comb begin
        xs        = r_x >>> r_cnt;
        ys        = r_y >>> r_cnt;
        step_ang  = signed'({4'b0, atan_q20(5'(r_cnt))});
        z_clamped = r_z[23] ? 24'sd0 : r_z;
        z_round   = unsigned'(z_clamped) + 24'd128;
    end

    assign o_angle = z_round[21:8];
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last rotation
            r_done <= !i_start && r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= signed'({3'b0, i_b, 20'b0});
            r_y <= signed'({3'b0, i_a, 20'b0});
            r_z <= '0;
        end else if (r_busy) begin
            if (!r_y[47]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + step_ang;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - step_ang;
            end
        end
    end

endmodule

@@ rtl/core/heading_to_point_pid.sv @@
// ----------------------------------------------------------------------------
// heading_to_point_pid
// turn controller: bearing to a target point, heading error and pid drive
// ----------------------------------------------------------------------------
// One item at a time. An item goes from acceptance through the start,
// arctangent, quadrant, error, multiply and output states to its result;
// the arctangent cordic, one rotation a cycle, takes most of that time,
// and the three pid products go through one shared 17 x 32 multiplier,
// one product a cycle, with one more step to add the last one. A zero y
// gap skips the cordic. The input is stalled while an item is in work.
// A finished result waits in the output register, and the next item can be
// taken meanwhile; that item then holds at its end until the output is free.
// Configuration writes are always ready and should be made while idle.
// ----------------------------------------------------------------------------
module heading_to_point_pid import hpid_pkg::*; #(
    parameter int CORDIC_STEPS = HPID_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [19:0] i_heading,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_power,
    output logic               o_done_res,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ATAN  = 3'd2;
    localparam logic [2:0] S_QUAD  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // configuration
    logic [15:0]        r_gain_p, r_gain_i, r_gain_d, r_window;
    logic               r_forward;
    logic signed [23:0] r_goal_x, r_goal_y;

    // persistent controller state
    logic signed [31:0] r_isum;
    logic signed [19:0] r_last;

    // per-item working registers
    logic [2:0]         r_state;
    logic signed [24:0] r_dx, r_dy;
    logic signed [19:0] r_hd;
    logic signed [17:0] r_t;
    logic signed [19:0] r_err;
    logic signed [20:0] r_deriv;
    logic               r_done;
    logic [1:0]         r_mcnt;
    logic signed [48:0] r_prod;
    logic signed [50:0] r_acc;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_power;
    logic               r_done_res;

    // cordic hookup
    logic               cor_start, cor_done;
    logic [13:0]        cor_angle;
    logic [24:0]        abs_dx, abs_dy;

    assign abs_dx    = r_dx[24] ? 25'(-r_dx) : unsigned'(r_dx);
    assign abs_dy    = r_dy[24] ? 25'(-r_dy) : unsigned'(r_dy);
    assign cor_start = (r_state == S_START) && (r_dy != '0);

    hpid_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_a     (abs_dx),
        .i_b     (abs_dy),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // quadrant placement of the unsigned bearing
    logic               dx_le0, dx_lt0, dx_ge0, dx_gt0, dy_gt0, dy_le0;
    logic signed [17:0] bear_quad, bear_fix;

    always_comb begin
        dx_lt0 = r_dx[24];
        dx_gt0 = !r_dx[24] && (r_dx != '0);
        dx_le0 = !dx_gt0;
        dx_ge0 = !dx_lt0;
        dy_gt0 = !r_dy[24] && (r_dy != '0);
        dy_le0 = !dy_gt0;
        bear_quad = r_t;
        if (r_forward) begin
            priority if (dx_le0 && dy_gt0) bear_quad = -r_t;
            else if (dx_lt0 && dy_le0)     bear_quad = PI_Q12 + r_t;
            else if (dx_ge0 && dy_le0)     bear_quad = PI_Q12 - r_t;
            else                           bear_quad = r_t;
        end else begin
            priority if (dx_gt0 && dy_gt0) bear_quad = PI_Q12 + r_t;
            else if (dx_le0 && dy_gt0)     bear_quad = PI_Q12 - r_t;
            else if (dx_ge0 && dy_le0)     bear_quad = -r_t;
            else                           bear_quad = r_t;
        end
        // behind the target by less than 7 units in y: flip
        bear_fix = (r_dy[24] && (abs_dy < NEAR_Y_Q8)) ? -bear_quad : bear_quad;
    end

    // error, windowed integral and derivative
    logic signed [20:0] err_wide, deriv_n;
    logic signed [19:0] err_n;
    logic [20:0]        err_abs;
    logic signed [32:0] isum_wide;
    logic signed [31:0] isum_n;
    logic               sign_flip;

    always_comb begin
        err_wide = 21'(r_t) - 21'(r_hd);
        if (err_wide[20] != err_wide[19])
            err_n = err_wide[20] ? 20'sh80000 : 20'sh7FFFF;
        else
            err_n = err_wide[19:0];
        err_abs   = err_n[19] ? 21'(-21'(err_n)) : 21'(unsigned'(err_n));
        isum_wide = 33'(r_isum) + 33'(err_n);
        isum_n    = r_isum;
        if (err_abs < {5'b0, r_window}) begin
            if (isum_wide[32] != isum_wide[31])
                isum_n = isum_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            else
                isum_n = isum_wide[31:0];
        end
        sign_flip = (!err_n[19] && err_n != '0 && r_last[19])
                 || (err_n[19] && !r_last[19] && r_last != '0);
        if (sign_flip)
            isum_n = '0;
        deriv_n = 21'(r_last) - 21'(err_n);
    end

    // target box: 20*|d| < 3*goal on both axes
    logic [29:0]        dx20, dy20;
    logic signed [26:0] gx3, gy3;
    logic               box_n;

    always_comb begin
        dx20  = (30'(abs_dx) << 4) + (30'(abs_dx) << 2);
        dy20  = (30'(abs_dy) << 4) + (30'(abs_dy) << 2);
        gx3   = 27'(r_goal_x) + (27'(r_goal_x) <<< 1);
        gy3   = 27'(r_goal_y) + (27'(r_goal_y) <<< 1);
        box_n = (signed'({1'b0, dx20}) < 31'(gx3))
             && (signed'({1'b0, dy20}) < 31'(gy3));
    end

    // shared multiplier: gain times term, one product a cycle
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;

    always_comb begin
        unique case (r_mcnt)
            2'd0:    begin mul_a = signed'({1'b0, r_gain_p}); mul_b = 32'(r_err);   end
            2'd1:    begin mul_a = signed'({1'b0, r_gain_i}); mul_b = r_isum;       end
            default: begin mul_a = signed'({1'b0, r_gain_d}); mul_b = 32'(r_deriv); end
        endcase
    end

    // rounding and saturation of the drive value
    logic signed [50:0] acc_round;
    logic signed [42:0] acc_shift;
    logic signed [31:0] power_n;

    always_comb begin
        acc_round = r_acc + 51'sd128;
        acc_shift = acc_round[50:8];
        if (acc_shift > 43'sh7FFFFFFF)
            power_n = 32'sh7FFFFFFF;
        else if (acc_shift < -43'sh80000000)
            power_n = 32'sh80000000;
        else
            power_n = acc_shift[31:0];
    end

    logic in_take, out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;
    assign o_done_res  = r_done_res;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_forward <= 1'b1;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_window  <= 16'd856;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:   r_gain_p  <= i_cfg_data[15:0];
                CFG_GAIN_I:   r_gain_i  <= i_cfg_data[15:0];
                CFG_GAIN_D:   r_gain_d  <= i_cfg_data[15:0];
                CFG_FORWARD:  r_forward <= i_cfg_data[0];
                CFG_GOAL_X:   r_goal_x  <= signed'(i_cfg_data);
                CFG_GOAL_Y:   r_goal_y  <= signed'(i_cfg_data);
                CFG_I_WINDOW: r_window  <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_isum      <= '0;
            r_last      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result or drop the one taken by the sink
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_take)
                        r_state <= S_START;
                end
                S_START: begin
                    r_state <= (r_dy == '0) ? S_QUAD : S_ATAN;
                end
                S_ATAN: begin
                    if (cor_done)
                        r_state <= S_QUAD;
                end
                S_QUAD: begin
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_isum  <= isum_n;
                    r_last  <= err_n;
                    r_mcnt  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd3)
                        r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dx <= 25'(r_goal_x) - 25'(i_pos_x);
            r_dy <= 25'(r_goal_y) - 25'(i_pos_y);
            r_hd <= i_heading;
        end
        if (r_state == S_START && r_dy == '0)
            r_t <= HALF_PI_Q12;
        if (r_state == S_ATAN && cor_done)
            r_t <= signed'({4'b0, cor_angle});
        if (r_state == S_QUAD)
            r_t <= bear_fix;
        if (r_state == S_ERR) begin
            r_err   <= err_n;
            r_deriv <= deriv_n;
            r_done  <= box_n;
            r_acc   <= '0;
        end
        if (r_state == S_MUL) begin
            if (r_mcnt != 2'd3)
                r_prod <= mul_a * mul_b;
            if (r_mcnt != 2'd0)
                r_acc <= r_acc + 51'(r_prod);
        end
        if (r_state == S_OUT && out_free) begin
            r_power    <= r_done ? 32'sd0 : power_n;
            r_done_res <= r_done;
        end
    end

endmodule

@@ rtl/core/hpid_checker.sv @@
// ----------------------------------------------------------------------------
// hpid_checker
// port-level checks of the heading to point turn controller
// ----------------------------------------------------------------------------
`include "heading_to_point_pid_assert.svh"

module hpid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_power,
    input logic               o_done_res,
    input logic               o_cfg_ready
);

    // a result waiting on a stalled sink stays offered
    `HPID_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid)
    // inside the target box the drive is zero
    `HPID_ASSERT(a_done_zero, (o_out_valid && o_done_res) |-> (o_power == 32'sd0))
    // an accepted item keeps the input side busy
    `HPID_ASSERT(a_busy_after_take, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // with no result waiting, none comes out the cycle after an item is taken
    `HPID_ASSERT(a_no_instant_result,
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
    // configuration port never back-pressures
    `HPID_ASSERT_ALWAYS(a_cfg_ready, o_cfg_ready)

endmodule

bind heading_to_point_pid hpid_checker u_hpid_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the heading to point turn controller: a queue-fed
// driver offers pose items, a monitor compares every result item against a
// bit-exact steering predictor, and the register set is changed between
// phases while the block is idle
// ----------------------------------------------------------------------------
module testbench;
    import hpid_pkg::*;

    localparam int  LIMIT_CYCLES = 500000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  MAX_REPORTS  = 10;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [19:0] hd;
    } t_pose;

    typedef struct {
        logic signed [31:0] power;
        logic               done;
    } t_steer;

    // atan(2^-i) in q20, one entry per cordic rotation
    localparam longint ATAN_Q20 [0:15] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [23:0] i_pos_x = '0;
    logic signed [23:0] i_pos_y = '0;
    logic signed [19:0] i_heading = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_power;
    logic               o_done_res;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;

    heading_to_point_pid dut (.*);

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the register set and the loop state
    longint gain_p, gain_i, gain_d, fwd, goal_x, goal_y, win;
    longint integ, last_err;

    t_pose  pose_q[$];
    t_steer steer_q[$];

    bit     quiet = 1'b0;      // no gaps or stalls in this phase
    int     hold_req = 0;      // bumped to ask the monitor for a long stall
    int     gap_left = 0;
    int     stall_left = 0;
    int     hold_seen = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     done_seen = 0;
    int     mismatches = 0;
    int     cycles = 0;
    int     phases = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // unsigned bearing atan(a/b) in q12, a >= 0, b > 0
    function automatic longint bearing_mag(longint a, longint b);
        longint x, y, z, xs, ys;
        x = b <<< 20;
        y = a <<< 20;
        z = 0;
        for (int i = 0; i < HPID_CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_Q20[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_Q20[i];
            end
        end
        if (z < 0)
            z = 0;
        return (z + 128) >>> 8;
    endfunction

    // steering result for one pose, advances the integral and last error
    function automatic t_steer steer_predict(t_pose p);
        longint dx, dy, t, err, deriv, sum;
        t_steer r;
        dx = goal_x - longint'(p.px);
        dy = goal_y - longint'(p.py);
        t = (dy == 0) ? longint'(HALF_PI_Q12) : bearing_mag(mag(dx), mag(dy));
        // quadrant fix-up
        if (fwd != 0) begin
            if (dx <= 0 && dy > 0)       t = -t;
            else if (dx < 0 && dy <= 0)  t = longint'(PI_Q12) + t;
            else if (dx >= 0 && dy <= 0) t = longint'(PI_Q12) - t;
        end else begin
            if (dx > 0 && dy > 0)        t = longint'(PI_Q12) + t;
            else if (dx <= 0 && dy > 0)  t = longint'(PI_Q12) - t;
            else if (dx >= 0 && dy <= 0) t = -t;
        end
        if (mag(dy) < longint'(NEAR_Y_Q8) && dy < 0)
            t = -t;
        err = clamp(t - longint'(p.hd), -524288, 524287);
        if (mag(err) < win)
            integ = clamp(integ + err, -64'sd2147483648, 64'sd2147483647);
        if ((err > 0 && last_err < 0) || (err < 0 && last_err > 0))
            integ = 0;
        deriv = last_err - err;
        last_err = err;
        sum = gain_p * err + gain_i * integ + gain_d * deriv;
        sum = clamp((sum + 128) >>> 8, -64'sd2147483648, 64'sd2147483647);
        r.done = (20 * mag(dx) < 3 * goal_x) && (20 * mag(dy) < 3 * goal_y);
        r.power = r.done ? 32'sd0 : 32'(sum);
        return r;
    endfunction

    // driver: one pose item per handshake, random gaps between items
    always @(posedge i_clk) begin
        t_pose p;
        int    g;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                steer_q.push_back(steer_predict('{i_pos_x, i_pos_y, i_heading}));
                items_sent <= items_sent + 1;
                g = quiet ? 0 : $urandom_range(0, 3);
                if (g == 0 && pose_q.size() != 0) begin
                    // keep valid high, next item straight away
                    p = pose_q.pop_front();
                    i_pos_x <= p.px; i_pos_y <= p.py; i_heading <= p.hd;
                end else begin
                    i_in_valid <= 1'b0;
                    gap_left <= g;
                end
            end else if (!i_in_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pose_q.size() != 0) begin
                    p = pose_q.pop_front();
                    i_pos_x <= p.px; i_pos_y <= p.py; i_heading <= p.hd;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: checks result items and draws receiver stalls
    always @(posedge i_clk) begin
        t_steer e;
        int     s;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (o_done_res)
                    done_seen <= done_seen + 1;
                if (steer_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result item: power=%0d done=%0b",
                                 o_power, o_done_res);
                end else begin
                    e = steer_q.pop_front();
                    if (o_power !== e.power || o_done_res !== e.done) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display({"mismatch at item %0d: power exp %0d got %0d,",
                                      " done exp %0b got %0b"},
                                     results_seen, e.power, o_power, e.done, o_done_res);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                // long receiver hold-off so the block backs up
                hold_seen <= hold_req;
                stall_left <= 400;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= stall_left > 1;
            end else if (o_out_valid && !i_out_stall) begin
                s = quiet ? 0 : $urandom_range(0, 3);
                stall_left <= s;
                i_out_stall <= s != 0;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, steer_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one register write; valid stays high across back-to-back writes
    task automatic cfg_write(logic [2:0] idx, longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[23:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_P:   gain_p = val & 16'hFFFF;
            CFG_GAIN_I:   gain_i = val & 16'hFFFF;
            CFG_GAIN_D:   gain_d = val & 16'hFFFF;
            CFG_FORWARD:  fwd    = val & 1;
            CFG_GOAL_X:   goal_x = longint'(signed'(val[23:0]));
            CFG_GOAL_Y:   goal_y = longint'(signed'(val[23:0]));
            CFG_I_WINDOW: win    = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic cfg_all(longint gp, longint gi, longint gd, longint fw,
                           longint gx, longint gy, longint wn);
        cfg_write(CFG_GAIN_P, gp);
        cfg_write(CFG_GAIN_I, gi);
        cfg_write(CFG_GAIN_D, gd);
        cfg_write(CFG_FORWARD, fw);
        cfg_write(CFG_GOAL_X, gx);
        cfg_write(CFG_GOAL_Y, gy);
        cfg_write(CFG_I_WINDOW, wn);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        phases++;
    endtask

    // wait until every item has gone through and the block has settled
    task automatic drain();
        while (pose_q.size() != 0 || i_in_valid || steer_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_pose(longint x, longint y, longint h);
        pose_q.push_back('{24'(x), 24'(y), 20'(h)});
    endfunction

    // random pose: mostly near the goal with a plausible heading
    function automatic void push_random();
        int     k;
        longint off_x, off_y;
        k = $urandom_range(0, 99);
        if (k < 65) begin
            off_x = (longint'($urandom_range(0, 4095)) - 2048) <<< $urandom_range(0, 8);
            off_y = (longint'($urandom_range(0, 4095)) - 2048) <<< $urandom_range(0, 8);
            push_pose(goal_x + off_x, goal_y + off_y,
                      longint'($urandom_range(0, 32767)) - 16384);
        end else if (k < 85) begin
            push_pose(longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                      longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                      longint'($urandom_range(0, 65535)) - 32768);
        end else begin
            push_pose($urandom(), $urandom(), $urandom());
        end
    endfunction

    initial begin
        longint gx, gy;
        gain_p = 0; gain_i = 0; gain_d = 0; fwd = 1;
        goal_x = 0; goal_y = 0; win = 856;
        integ = 0; last_err = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: goal at (10, 20), both quadrant rule sets
        for (int f = 1; f >= 0; f--) begin
            quiet = 1'b1;
            cfg_all(256, 64, 128, f, 2560, 5120, 856);
            push_pose(2560, 5120, 0);            // on the goal, zero dx and dy
            push_pose(0, 5120, 100);             // zero dy, dx positive
            push_pose(5120, 5120, -100);         // zero dy, dx negative
            push_pose(0, 0, 1850);               // first quadrant, small error
            push_pose(0, 0, 1950);               // error changes sign
            push_pose(5120, 0, 0);               // dx negative, dy positive
            push_pose(0, 10240, 0);              // dy negative, far
            push_pose(5120, 10240, 0);           // both negative
            push_pose(1000, 5600, 0);            // dy just below goal, near band
            push_pose(2400, 4900, 0);            // inside the done box
            push_pose(24'h7FFFFF, 24'h7FFFFF, 20'h7FFFF);
            push_pose(-24'sd8388608, -24'sd8388608, -20'sd524288);
            push_pose(24'h7FFFFF, -24'sd8388608, 20'h7FFFF);
            drain();
        end

        // random phases, extremes of the register set among them
        for (int k = 0; k < 8; k++) begin
            quiet = (k == 5);
            gx = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            gy = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            case (k)
                2: begin gx = 24'sh7FFFFF; gy = 24'sh7FFFFF; end
                3: begin gx = -8388608; gy = -8388608; end
                4: begin gx = 0; gy = 0; end
                6: begin
                    gx = $urandom_range(256, 1 << 20);
                    gy = $urandom_range(256, 1 << 20);
                end
                default: ;
            endcase
            cfg_all(k == 0 ? 0 : (k == 1 ? 65535 : $urandom_range(0, 65535)),
                    k == 0 ? 0 : (k == 1 ? 65535 : $urandom_range(0, 65535)),
                    k == 0 ? 0 : (k == 1 ? 65535 : $urandom_range(0, 65535)),
                    k % 2, gx, gy,
                    k == 1 ? 65535 : (k == 2 ? 0 : $urandom_range(0, 4000)));
            for (int n = 0; n < 185; n++)
                push_random();
            if (k == 3)
                hold_req++;
            drain();
        end

        $display("covered %0d items over %0d register settings, %0d results inside the goal box",
                 items_sent, phases, done_seen);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && steer_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hpid_pkg.sv
rtl/core/hpid_cordic.sv
rtl/core/heading_to_point_pid.sv
rtl/core/hpid_checker.sv
sim/testbench.sv
